>>> rtl/core/pcrc_pkg.sv
package pcrc_pkg;

    // Widths fixed by the item format.
    localparam int KNOT_W  = 24;
    localparam int RANGE_W = 16;
    localparam int CORR_W  = 32;
    localparam int DX_W    = 24;

    // Function codes of an input beat.
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    // Clamp region codes.
    typedef enum logic [1:0] {
        REGION_INSIDE = 2'd0,
        REGION_LOW    = 2'd1,
        REGION_HIGH   = 2'd2
    } t_region;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SEG_COUNT = 2'd0;
    localparam logic [1:0] REG_MIN_CAL   = 2'd1;
    localparam logic [1:0] REG_MAX_CAL   = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HORNER,
        ST_ROUND,
        ST_OUT
    } t_state;

    // Search status handed down the chain of cells.
    typedef struct packed {
        logic       found;
        logic [7:0] hit;
    } t_scan;

endpackage

>>> rtl/core/pcrc_cell.sv
module pcrc_cell #(
    parameter int COEF_WIDTH = 48,
    parameter int IDX_W      = 4
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [pcrc_pkg::KNOT_W-1:0] i_start,
    input  logic [pcrc_pkg::KNOT_W-1:0] i_end,
    input  logic [4*COEF_WIDTH-1:0] i_coefs,
    input  logic [pcrc_pkg::KNOT_W-1:0] i_x,
    input  logic                    i_last,
    input  logic [IDX_W-1:0]        i_slot,
    input  logic                    i_in_use,
    input  pcrc_pkg::t_scan         i_scan,
    output pcrc_pkg::t_scan         o_scan,
    output logic [pcrc_pkg::KNOT_W-1:0] o_start,
    output logic [4*COEF_WIDTH-1:0] o_coefs
);
    import pcrc_pkg::*;

    logic [KNOT_W-1:0]       r_start;
    logic [KNOT_W-1:0]       r_end;
    logic [4*COEF_WIDTH-1:0] r_coefs;
    logic                    seg_hit;

    // One segment slot is held in this cell.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_start <= i_start;
            r_end   <= i_end;
            r_coefs <= i_coefs;
        end
    end

    // Cover test; the last slot in use also holds its end knot.
    always_comb begin
        seg_hit = i_in_use && (i_x >= r_start) &&
                  (i_last ? (i_x <= r_end) : (i_x < r_end));
        o_scan = i_scan;
        if (!i_scan.found && seg_hit) begin
            o_scan.found = 1'b1;
            o_scan.hit   = 8'(i_slot);
        end
    end

    assign o_start = r_start;
    assign o_coefs = r_coefs;
endmodule

>>> rtl/core/pcrc_horner.sv
module pcrc_horner #(
    parameter int COEF_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcrc_pkg::DX_W-1:0]     i_dx,
    input  logic signed [COEF_WIDTH-1:0]  i_init,
    input  logic signed [COEF_WIDTH-1:0]  i_coef,
    output logic [1:0]                    o_step,
    output logic                          o_done,
    output logic signed [COEF_WIDTH-1:0]  o_acc
);
    import pcrc_pkg::*;

    localparam int PW = COEF_WIDTH + DX_W + 1;
    localparam int HALF = (COEF_WIDTH + 1) / 2;
    localparam logic signed [COEF_WIDTH-1:0] CMAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0] CMIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    // Phase 0 multiplies the low half, phase 1 the high half, phase 2 adds.
    logic signed [COEF_WIDTH-1:0] r_acc, n_acc;
    logic signed [PW-1:0]         r_prod, n_prod;
    logic [1:0]                   r_phase, n_phase;
    logic [1:0]                   r_step, n_step;
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;

    logic signed [PW-1:0]         part;
    logic signed [PW-8-1:0]       quo;
    logic signed [COEF_WIDTH-1:0] t_sat;
    logic signed [COEF_WIDTH:0]   sum;
    logic [HALF-1:0]              lo_bits;
    logic signed [COEF_WIDTH-HALF:0] hi_bits;

    always_comb begin
        lo_bits = r_acc[HALF-1:0];
        hi_bits = (COEF_WIDTH-HALF+1)'($signed(r_acc[COEF_WIDTH-1:HALF]));
        if (r_phase == 2'd0) begin
            part = PW'($signed({1'b0, lo_bits}) * $signed({1'b0, i_dx}));
        end else begin
            part = PW'(hi_bits * $signed({1'b0, i_dx})) <<< HALF;
        end
        quo = (PW-8)'(r_prod >>> 8);
        if (quo > (PW-8)'(CMAX)) begin
            t_sat = CMAX;
        end else if (quo < (PW-8)'(CMIN)) begin
            t_sat = CMIN;
        end else begin
            t_sat = COEF_WIDTH'(quo);
        end
        sum = (COEF_WIDTH+1)'(t_sat) + (COEF_WIDTH+1)'(i_coef);
    end

    always_comb begin
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_phase = r_phase;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_acc   = i_init;
            n_phase = 2'd0;
            n_step  = 2'd0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            unique case (r_phase)
                2'd0: begin
                    n_prod  = part;
                    n_phase = 2'd1;
                end
                2'd1: begin
                    n_prod  = r_prod + part;
                    n_phase = 2'd2;
                end
                default: begin
                    if (sum > (COEF_WIDTH+1)'(CMAX)) n_acc = CMAX;
                    else if (sum < (COEF_WIDTH+1)'(CMIN)) n_acc = CMIN;
                    else n_acc = COEF_WIDTH'(sum);
                    n_phase = 2'd0;
                    if (r_step == 2'd2) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 2'd0;
            r_step  <= 2'd0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_phase <= n_phase;
            r_step  <= n_step;
        end
        r_acc  <= n_acc;
        r_prod <= n_prod;
    end

    assign o_step = r_step;
    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

>>> rtl/core/piecewise_cubic_range_correction_top.sv
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_stall  | func, seg_index, knots, coefs, raw_range
// output  | out       | o_valid / i_stall  | correction, region, no_segment
// config  | in        | APB psel/penable   | segment_count, min/max_cal_range
// A load beat is accepted, then written to its slot from the r_load register.
// An evaluate beat runs the scan over all MAX_SEGMENTS slots, three Horner steps on
// the shared multiplier, the rounding state and the result beat before the next accept.
// Reset is synchronous and clears control state; segment slots hold unknown data.
// The result register holds while i_stall is high; the next beat is taken after it leaves.
module piecewise_cubic_range_correction_top #(
    parameter int MAX_SEGMENTS = 16,
    parameter int COEF_WIDTH   = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [3:0]                    i_seg_index,
    input  logic [23:0]                   i_knot_start,
    input  logic [23:0]                   i_knot_end,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_const,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_lin,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_quad,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_cube,
    input  logic [15:0]                   i_raw_range,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_correction,
    output logic [1:0]                    o_region,
    output logic                          o_no_segment,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pcrc_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int CW4   = 4 * COEF_WIDTH;

    // Configuration registers.
    logic [4:0]  r_seg_count;
    logic [15:0] r_min_cal, r_max_cal;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= 5'd1;
            r_min_cal   <= 16'd0;
            r_max_cal   <= 16'hFFFF;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SEG_COUNT: r_seg_count <= pwdata[4:0];
                REG_MIN_CAL:   r_min_cal   <= pwdata[15:0];
                REG_MAX_CAL:   r_max_cal   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SEG_COUNT: prdata = {27'd0, r_seg_count};
            REG_MIN_CAL:   prdata = {16'd0, r_min_cal};
            REG_MAX_CAL:   prdata = {16'd0, r_max_cal};
            default:       prdata = 32'd0;
        endcase
    end

    // Sequencer.
    t_state r_state, n_state;
    logic   in_acc, out_acc;
    logic   hn_done;
    logic [CNT_W-1:0] r_cnt;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Captured beat.
    logic              r_load;
    logic [3:0]        r_slot;
    logic [KNOT_W-1:0] r_kstart, r_kend;
    logic [CW4-1:0]    r_coefs;
    logic [KNOT_W-1:0] r_x;
    t_region           r_region;
    logic [CNT_W-1:0]  use_cnt;

    always_comb begin
        use_cnt = (32'(r_seg_count) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                    : CNT_W'(r_seg_count);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc) n_state = (t_func'(i_func) == FUNC_EVAL) ? ST_SCAN : ST_IDLE;
            ST_SCAN:   if (r_cnt == CNT_W'(MAX_SEGMENTS)) n_state = ST_HORNER;
            ST_HORNER: if (hn_done) n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_OUT;
            ST_OUT:    if (out_acc) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE) || r_load;
        o_valid = (r_state == ST_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_load  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_load  <= in_acc && (t_func'(i_func) == FUNC_LOAD);
            if (r_state == ST_SCAN) r_cnt <= r_cnt + CNT_W'(1);
            else r_cnt <= '0;
        end
    end

    // Beat capture and clamping.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot   <= i_seg_index;
            r_kstart <= i_knot_start;
            r_kend   <= i_knot_end;
            r_coefs  <= {i_coef_cube, i_coef_quad, i_coef_lin, i_coef_const};
            if (i_raw_range < r_min_cal) begin
                r_x <= {r_min_cal, 8'd0}; r_region <= REGION_LOW;
            end else if (i_raw_range >= r_max_cal) begin
                r_x <= {r_max_cal, 8'd0}; r_region <= REGION_HIGH;
            end else begin
                r_x <= {i_raw_range, 8'd0}; r_region <= REGION_INSIDE;
            end
        end
    end

    // Chain of cells: the scan status walks one cell per cycle.
    t_scan             chain [MAX_SEGMENTS+1];
    logic [KNOT_W-1:0] c_start [MAX_SEGMENTS];
    logic [CW4-1:0]    c_coefs [MAX_SEGMENTS];
    t_scan             r_scan;
    logic [IDX_W-1:0]  scan_pos;

    assign scan_pos = IDX_W'(r_cnt);
    assign chain[0] = '0;

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        logic we, act;
        assign we  = r_load && (32'(r_slot) == g);
        assign act = (r_state == ST_SCAN) && (r_cnt < CNT_W'(MAX_SEGMENTS)) &&
                     (32'(scan_pos) == g);
        pcrc_cell #(.COEF_WIDTH(COEF_WIDTH), .IDX_W(IDX_W)) u_cell (
            .i_clk    (i_clk),
            .i_we     (we),
            .i_start  (r_kstart),
            .i_end    (r_kend),
            .i_coefs  (r_coefs),
            .i_x      (r_x),
            .i_last   (32'(use_cnt) == g + 1),
            .i_slot   (IDX_W'(g)),
            .i_in_use (act && (32'(use_cnt) > g)),
            .i_scan   (act ? r_scan : chain[g]),
            .o_scan   (chain[g+1]),
            .o_start  (c_start[g]),
            .o_coefs  (c_coefs[g])
        );
    end

    // During the scan the scan register takes the output of the active cell each cycle; idle clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (r_state == ST_IDLE) begin
            r_scan <= '0;
        end else if (r_state == ST_SCAN && r_cnt < CNT_W'(MAX_SEGMENTS)) begin
            r_scan <= chain[32'(scan_pos) + 1];
        end
    end

    // Selected segment feeds the Horner unit.
    logic [IDX_W-1:0] hit;
    logic [DX_W-1:0]  dx;
    logic [CW4-1:0]   sel_coefs;
    logic [1:0]       hn_step;
    logic signed [COEF_WIDTH-1:0] hn_coef, hn_acc;
    logic             hn_go;

    assign hit       = IDX_W'(r_scan.hit);
    assign sel_coefs = c_coefs[hit];
    assign dx        = r_x - c_start[hit];
    assign hn_go     = (r_state == ST_SCAN) && (r_cnt == CNT_W'(MAX_SEGMENTS));

    always_comb begin
        unique case (hn_step)
            2'd0:    hn_coef = sel_coefs[2*COEF_WIDTH +: COEF_WIDTH];
            2'd1:    hn_coef = sel_coefs[COEF_WIDTH +: COEF_WIDTH];
            default: hn_coef = sel_coefs[0 +: COEF_WIDTH];
        endcase
    end

    pcrc_horner #(.COEF_WIDTH(COEF_WIDTH)) u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hn_go),
        .i_dx    (dx),
        .i_init  (sel_coefs[3*COEF_WIDTH +: COEF_WIDTH]),
        .i_coef  (hn_coef),
        .o_step  (hn_step),
        .o_done  (hn_done),
        .o_acc   (hn_acc)
    );

    // Round half up to Q16.16 and saturate.
    logic signed [COEF_WIDTH-16:0] rnd;
    assign rnd = (COEF_WIDTH-15)'(hn_acc >>> 16) + (COEF_WIDTH-15)'(hn_acc[15]);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND) begin
            o_region     <= r_region;
            o_no_segment <= !r_scan.found;
            if (!r_scan.found) o_correction <= '0;
            else if (64'(rnd) > 64'sh7FFFFFFF) o_correction <= 32'sh7FFFFFFF;
            else if (64'(rnd) < -64'sh80000000) o_correction <= 32'sh80000000;
            else o_correction <= 32'(rnd);
        end
    end

    // Checks.
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while a result waits");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_correction))
        else $error("result changed under stall");
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_segment |-> o_correction == 32'sd0)
        else $error("uncovered range with nonzero correction");
endmodule
